// ===== hw/rtl/per_symbol_ema_threshold_signal_assert.svh =====
// Assertion macros used by the checker file psets_checker.sv.
`ifndef PER_SYMBOL_EMA_THRESHOLD_SIGNAL_ASSERT_SVH
`define PER_SYMBOL_EMA_THRESHOLD_SIGNAL_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PSETS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, off while reset is high.
`define PSETS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define PSETS_ASSERT_NEXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

// ===== hw/rtl/psets_pkg.sv =====
package psets_pkg;

  localparam int SYM_W      = 64;
  localparam int PRICE_W    = 48;
  localparam int TIME_W     = 64;
  localparam int WEIGHT_W   = 17;
  localparam int MARGIN_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = PRICE_W + WEIGHT_W;
  localparam int BAND_W     = PRICE_W + MARGIN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd6242;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMA_WEIGHT  = 1'b0,
    REG_BAND_MARGIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_t;

  // what the lookup found for a tick
  typedef enum logic [1:0] {
    CLS_HIT = 2'd0,
    CLS_NEW = 2'd1,
    CLS_OVF = 2'd2
  } slot_class_t;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  stamp;
    slot_class_t        cls;
  } job_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [MARGIN_W-1:0] margin;
  } cfg_t;

endpackage

// ===== hw/rtl/psets_if.sv =====
interface psets_tick_if import psets_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   ticker_symbol;
  logic [PRICE_W-1:0] trade_price;
  logic [TIME_W-1:0]  event_time;

  modport source (output valid, ticker_symbol, trade_price, event_time, input ready);
  modport sink   (input valid, ticker_symbol, trade_price, event_time, output ready);
endinterface

interface psets_result_if import psets_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   out_symbol;
  logic [PRICE_W-1:0] out_price;
  logic [PRICE_W-1:0] average_price;
  logic [TIME_W-1:0]  out_time;
  logic [1:0]         signal_kind;
  logic               table_overflow;

  modport source (output valid, out_symbol, out_price, average_price, out_time,
                  signal_kind, table_overflow, input ready);
  modport sink   (input valid, out_symbol, out_price, average_price, out_time,
                  signal_kind, table_overflow, output ready);
endinterface

// ===== hw/rtl/psets_queue.sv =====
module psets_queue import psets_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  job_t             push_job,
  input  logic [IDX_W-1:0] push_slot,
  output logic             pop_valid,
  input  logic             pop_ready,
  output job_t             pop_job,
  output logic [IDX_W-1:0] pop_slot
);

  localparam int DEPTH = 2;

  job_t             job_mem  [DEPTH];
  logic [IDX_W-1:0] slot_mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = job_mem[rd_ptr];
  assign pop_slot   = slot_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      job_mem[wr_ptr]  <= push_job;
      slot_mem[wr_ptr] <= push_slot;
    end
  end

endmodule

// ===== hw/rtl/psets_front.sv =====
module psets_front import psets_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  psets_tick_if.sink       tick,
  output logic             push_valid,
  input  logic             push_ready,
  output job_t             push_job,
  output logic [IDX_W-1:0] push_slot
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t          state;
  job_t             job;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] filled;
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [SYM_W-1:0] key_q;
  logic [SYM_W-1:0] key_mem [SLOTS];

  logic             rd_ok;
  logic             hit;
  logic             last;
  slot_class_t      miss_cls;
  logic [IDX_W-1:0] miss_slot;

  assign tick.ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_job   = job;
  assign push_slot  = slot;

  assign rd_ok     = (scan_idx < filled);
  assign hit       = cmp_valid && (key_q == job.symbol);
  assign last      = cmp_valid && ((CNT_W'(cmp_idx) + CNT_W'(1)) == filled);
  assign miss_cls  = (filled < CNT_W'(SLOTS)) ? CLS_NEW : CLS_OVF;
  assign miss_slot = filled[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      filled    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (tick.valid) begin
            job.symbol <= tick.ticker_symbol;
            job.price  <= tick.trade_price;
            job.stamp  <= tick.event_time;
            scan_idx   <= '0;
            cmp_valid  <= 1'b0;
            if (filled == '0) begin
              job.cls <= miss_cls;
              slot    <= miss_slot;
              state   <= F_PUSH;
            end else begin
              state <= F_SCAN;
            end
          end
        end
        F_SCAN: begin
          // read of scan_idx issues now, compare of cmp_idx lands now
          scan_idx  <= scan_idx + CNT_W'(1);
          cmp_valid <= rd_ok;
          cmp_idx   <= scan_idx[IDX_W-1:0];
          if (hit) begin
            job.cls   <= CLS_HIT;
            slot      <= cmp_idx;
            cmp_valid <= 1'b0;
            state     <= F_PUSH;
          end else if (last) begin
            job.cls   <= miss_cls;
            slot      <= miss_slot;
            cmp_valid <= 1'b0;
            state     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            if (job.cls == CLS_NEW) filled <= filled + CNT_W'(1);
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_SCAN && rd_ok) key_q <= key_mem[scan_idx[IDX_W-1:0]];
    if (state == F_PUSH && push_ready && job.cls == CLS_NEW) key_mem[slot] <= job.symbol;
  end

endmodule

// ===== hw/rtl/psets_back.sv =====
module psets_back import psets_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  job_t             pop_job,
  input  logic [IDX_W-1:0] pop_slot,
  psets_result_if.source   result
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_UPD  = 4'b0100,
    B_DEC  = 4'b1000
  } bstate_t;

  bstate_t              state;
  job_t                 job;
  logic [IDX_W-1:0]     slot;
  logic [PRICE_W-1:0]   avg_q;
  logic [PRICE_W-1:0]   ema_q;
  logic                 below_q;
  logic [PROD_W-1:0]    prod;
  logic [BAND_W-1:0]    band;
  logic [PRICE_W-1:0]   ema_new;
  logic [PRICE_W-1:0]   avg_mem [SLOTS];

  logic                 out_valid;
  logic [SYM_W-1:0]     out_symbol;
  logic [PRICE_W-1:0]   out_price;
  logic [PRICE_W-1:0]   out_avg;
  logic [TIME_W-1:0]    out_time;
  signal_t              out_sig;
  logic                 out_ovf;

  logic [PRICE_W-1:0]        ema_cur;
  logic                      below;
  logic [PRICE_W-1:0]        diff;
  logic [WEIGHT_W-1:0]       alpha;
  logic [PROD_W-FRAC_W-1:0]  step_floor;
  logic [PROD_W-FRAC_W-1:0]  step_ceil;
  logic [BAND_W-1:0]         up_gap;
  logic [BAND_W-1:0]         dn_gap;
  signal_t                   sig;
  logic                      load;

  assign pop_ready = (state == B_IDLE);

  // first tick and table-full ticks start from the price itself
  assign ema_cur = (job.cls == CLS_HIT) ? avg_q : job.price;
  assign below   = (job.price < ema_cur);
  assign diff    = below ? (ema_cur - job.price) : (job.price - ema_cur);
  assign alpha   = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;

  // moving down rounds the step up, so both directions floor the result
  assign step_floor = prod[PROD_W-1:FRAC_W];
  assign step_ceil  = prod[PROD_W-1:FRAC_W] + (PROD_W-FRAC_W)'(|prod[FRAC_W-1:0]);

  assign up_gap = {job.price - ema_new, {FRAC_W{1'b0}}};
  assign dn_gap = {ema_new - job.price, {FRAC_W{1'b0}}};

  always_comb begin
    priority if (job.price > ema_new && up_gap > band) sig = SIG_BUY;
    else if (ema_new > job.price && dn_gap > band)     sig = SIG_SELL;
    else                                              sig = SIG_HOLD;
  end

  assign load = (state == B_DEC) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load)              out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (pop_valid) begin
          job   <= pop_job;
          slot  <= pop_slot;
          state <= B_MUL;
        end
        B_MUL: begin
          ema_q   <= ema_cur;
          below_q <= below;
          prod    <= PROD_W'(diff) * PROD_W'(alpha);
          band    <= BAND_W'(job.price) * BAND_W'(cfg.margin);
          state   <= B_UPD;
        end
        B_UPD: begin
          ema_new <= below_q ? (ema_q - step_ceil[PRICE_W-1:0])
                             : (ema_q + step_floor[PRICE_W-1:0]);
          state   <= B_DEC;
        end
        B_DEC: if (load) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE) avg_q <= avg_mem[pop_slot];
    if (load && job.cls != CLS_OVF) avg_mem[slot] <= ema_new;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_symbol <= job.symbol;
      out_price  <= job.price;
      out_avg    <= ema_new;
      out_time   <= job.stamp;
      out_sig    <= sig;
      out_ovf    <= (job.cls == CLS_OVF);
    end
  end

  assign result.valid          = out_valid;
  assign result.out_symbol     = out_symbol;
  assign result.out_price      = out_price;
  assign result.average_price  = out_avg;
  assign result.out_time       = out_time;
  assign result.signal_kind    = out_sig;
  assign result.table_overflow = out_ovf;

endmodule

// ===== hw/rtl/per_symbol_ema_threshold_signal.sv =====
// Per-symbol moving average with a buy/sell/hold band. Each tick gives exactly
// one result, in order. The front looks the symbol up by scanning the key
// memory one entry per cycle through its single read port, skips the scan when
// the table is empty, and takes a new tick only once it has pushed the last one.
// A two-entry queue hands the tick to the back, which reads the stored average,
// multiplies, updates and compares, and pops the next tick only once the last
// result is loaded into its output register. Slots are taken in order and never
// freed; there is no clearing pass after reset. Write the ema_weight and
// band_margin registers only while no tick is in flight.
module per_symbol_ema_threshold_signal import psets_pkg::*; #(
  parameter int SYMBOL_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  psets_tick_if.sink            tick,
  psets_result_if.source        result
);

  localparam int IDX_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
  localparam int CNT_W = $clog2(SYMBOL_SLOTS + 1);

  cfg_t             cfg;
  logic             push_valid;
  logic             push_ready;
  job_t             push_job;
  logic [IDX_W-1:0] push_slot;
  logic             pop_valid;
  logic             pop_ready;
  job_t             pop_job;
  logic [IDX_W-1:0] pop_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight <= WEIGHT_RST;
      cfg.margin <= MARGIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EMA_WEIGHT:  cfg.weight <= cfg_data[WEIGHT_W-1:0];
        REG_BAND_MARGIN: cfg.margin <= cfg_data[MARGIN_W-1:0];
      endcase
    end
  end

  psets_front #(
    .SLOTS (SYMBOL_SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .push_slot  (push_slot)
  );

  psets_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .push_slot  (push_slot),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .pop_slot   (pop_slot)
  );

  psets_back #(
    .SLOTS (SYMBOL_SLOTS),
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .pop_slot  (pop_slot),
    .result    (result)
  );

endmodule

// ===== hw/rtl/psets_checker.sv =====
`include "per_symbol_ema_threshold_signal_assert.svh"

module psets_checker import psets_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [SYM_W-1:0]   out_symbol,
  input logic [PRICE_W-1:0] out_price,
  input logic [PRICE_W-1:0] average_price,
  input logic [TIME_W-1:0]  out_time,
  input logic [1:0]         signal_kind,
  input logic               table_overflow
);

  logic [SYM_W+2*PRICE_W+TIME_W+2:0] payload;

  assign payload = {out_symbol, out_price, average_price, out_time, signal_kind,
                    table_overflow};

  `PSETS_ASSERT_NEXT_RAW(no_result_after_reset, clk, rst, !res_valid)
  `PSETS_ASSERT_NEXT(stalled_result_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(payload))
  // a symbol that found no slot keeps the tick price as its average
  `PSETS_ASSERT_IMPLY(overflow_avg_is_price, clk, rst, res_valid && table_overflow, average_price == out_price)
  `PSETS_ASSERT_IMPLY(flat_avg_holds, clk, rst, res_valid && average_price == out_price, signal_kind == SIG_HOLD)

endmodule

bind per_symbol_ema_threshold_signal psets_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .out_symbol     (result.out_symbol),
  .out_price      (result.out_price),
  .average_price  (result.average_price),
  .out_time       (result.out_time),
  .signal_kind    (result.signal_kind),
  .table_overflow (result.table_overflow)
);
